@@ hdl/htd_pkg.sv @@
package htd_pkg;

  // node store geometry
  localparam int unsigned NODES   = 512;
  localparam int unsigned NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // one stored tree node, leaf flag in the top bit
  typedef struct packed {
    logic       is_leaf;
    logic [7:0] symbol;
    logic [8:0] left;
    logic [8:0] right;
  } node_t;

  typedef struct packed {
    logic       opcode;
    logic [8:0] node_index;
    logic       node_is_leaf;
    logic [7:0] node_symbol;
    logic [8:0] left_child;
    logic [8:0] right_child;
    logic [7:0] coded_byte;
    logic [3:0] bits_used;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_FLUSH
  } htd_state_t;

  // true when a node index lies inside the store
  function automatic logic node_ok(input logic [8:0] idx);
    return ({2'b00, idx} < 11'(NODES));
  endfunction

  // store address of a node index
  function automatic logic [NODE_AW-1:0] node_addr(input logic [8:0] idx);
    return NODE_AW'(idx);
  endfunction

endpackage

@@ hdl/huffman_tree_decoder.sv @@
// Huffman code tree walker. Node-write items load the node store and return the walk
// to the root; the cfg port sets the root index and also returns the walk to it. A
// decode item is accepted, then takes one step per valid coded bit, an extra step for
// every symbol reached through a child node, and a closing flush of the held symbol.
// The pace is set by the single read port of the node store: each bit needs the entry
// of the node it leaves, read in the cycle before. Stalls on the result channel hold
// the walk. Symbols leave one per transfer, the final one of a byte marked by last; a
// byte that reaches no leaf gives no transfer.
module huffman_tree_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  htd_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output htd_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [8:0]           cfg_data
);

  // node store
  htd_pkg::node_t              mem [htd_pkg::NODES];
  htd_pkg::node_t              mem_q_r;
  logic                        mem_oor_r;
  logic                        mem_we;
  logic [htd_pkg::NODE_AW-1:0] mem_waddr;
  htd_pkg::node_t              mem_wdata;
  logic                        mem_re;
  logic [8:0]                  mem_ridx;
  htd_pkg::node_t              rd_node;

  // control and walk state
  htd_pkg::htd_state_t state_r, state_nxt;
  logic [8:0]          root_r, root_nxt;
  logic [8:0]          walk_r, walk_nxt;
  htd_pkg::node_t      root_entry_r, root_entry_nxt;
  logic                rcap_r, rcap_nxt;
  logic                sel_mem_r, sel_mem_nxt;
  logic                pend_r, pend_nxt;
  logic [3:0]          bits_left_r, bits_left_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [7:0]          hold_sym_r, hold_sym_nxt;
  logic                hold_v_r, hold_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  htd_pkg::out_item_t  out_data_r, out_data_nxt;

  logic           in_xfer;
  logic           cfg_xfer;
  logic           out_free;
  htd_pkg::node_t cur;
  htd_pkg::node_t new_node;
  logic           bits_done;

  // handshakes
  assign cfg_ready = (state_r == htd_pkg::ST_IDLE);
  assign in_ready  = (state_r == htd_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // read data, out-of-range reads give an empty inner node
  assign rd_node = mem_oor_r ? '0 : mem_q_r;
  assign cur     = sel_mem_r ? rd_node : root_entry_r;

  assign new_node = '{is_leaf: in_data.node_is_leaf, symbol: in_data.node_symbol,
                      left: in_data.left_child, right: in_data.right_child};
  assign bits_done = (bits_left_r == 4'd0);

  // node store access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r   <= mem[htd_pkg::node_addr(mem_ridx)];
      mem_oor_r <= !htd_pkg::node_ok(mem_ridx);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      htd_pkg::ST_IDLE: begin
        if (in_xfer && (in_data.opcode == htd_pkg::OP_DECODE)) begin
          state_nxt = htd_pkg::ST_BIT;
        end
      end
      htd_pkg::ST_BIT: begin
        if (bits_done && !(pend_r && cur.is_leaf)) begin
          state_nxt = htd_pkg::ST_FLUSH;
        end
      end
      htd_pkg::ST_FLUSH: begin
        if (!hold_v_r || out_free) begin
          state_nxt = htd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    root_nxt       = root_r;
    walk_nxt       = walk_r;
    root_entry_nxt = root_entry_r;
    rcap_nxt       = 1'b0;
    sel_mem_nxt    = sel_mem_r;
    pend_nxt       = pend_r;
    bits_left_nxt  = bits_left_r;
    byte_nxt       = byte_r;
    hold_sym_nxt   = hold_sym_r;
    hold_v_nxt     = hold_v_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = htd_pkg::node_addr(in_data.node_index);
    mem_wdata      = new_node;
    mem_re         = 1'b0;
    mem_ridx       = walk_r;

    // pick up the root entry read after a root change
    if (rcap_r) begin
      root_entry_nxt = rd_node;
    end

    case (state_r)
      htd_pkg::ST_IDLE: begin
        if (cfg_xfer) begin
          root_nxt = cfg_data;
          walk_nxt = cfg_data;
          mem_re   = 1'b1;
          mem_ridx = cfg_data;
          rcap_nxt = 1'b1;
        end else if (in_xfer) begin
          if (in_data.opcode == htd_pkg::OP_WRITE) begin
            mem_we   = htd_pkg::node_ok(in_data.node_index);
            walk_nxt = root_r;
            if (mem_we && (in_data.node_index == root_r)) begin
              root_entry_nxt = new_node;
            end
          end else begin
            // fetch the node at the walk position for the first bit
            mem_re        = 1'b1;
            mem_ridx      = walk_r;
            sel_mem_nxt   = 1'b1;
            pend_nxt      = 1'b0;
            byte_nxt      = in_data.coded_byte;
            bits_left_nxt = (in_data.bits_used > htd_pkg::BYTE_BITS) ?
                            htd_pkg::BYTE_BITS : in_data.bits_used;
          end
        end
      end
      htd_pkg::ST_BIT: begin
        if ((pend_r || !bits_done) && cur.is_leaf) begin
          // leaf reached: hold its symbol, push the one held before
          if (!hold_v_r || out_free) begin
            if (hold_v_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{symbol: hold_sym_r, last: 1'b0};
            end
            hold_sym_nxt = cur.symbol;
            hold_v_nxt   = 1'b1;
            walk_nxt     = root_r;
            sel_mem_nxt  = 1'b0;
            pend_nxt     = 1'b0;
            if (!pend_r) begin
              bits_left_nxt = bits_left_r - 4'd1;
              byte_nxt      = {byte_r[6:0], 1'b0};
            end
          end
        end else if (!bits_done) begin
          // inner node: step to the child chosen by the bit
          walk_nxt      = byte_r[7] ? cur.right : cur.left;
          mem_re        = 1'b1;
          mem_ridx      = walk_nxt;
          sel_mem_nxt   = 1'b1;
          pend_nxt      = 1'b1;
          bits_left_nxt = bits_left_r - 4'd1;
          byte_nxt      = {byte_r[6:0], 1'b0};
        end else begin
          pend_nxt = 1'b0;
        end
      end
      htd_pkg::ST_FLUSH: begin
        // final symbol of the byte
        if (hold_v_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{symbol: hold_sym_r, last: 1'b1};
          hold_v_nxt    = 1'b0;
        end
      end
      default: begin
        hold_v_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htd_pkg::ST_IDLE;
      root_r      <= '0;
      walk_r      <= '0;
      rcap_r      <= 1'b0;
      sel_mem_r   <= 1'b0;
      pend_r      <= 1'b0;
      bits_left_r <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      walk_r      <= walk_nxt;
      rcap_r      <= rcap_nxt;
      sel_mem_r   <= sel_mem_nxt;
      pend_r      <= pend_nxt;
      bits_left_r <= bits_left_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    root_entry_r <= root_entry_nxt;
    byte_r       <= byte_nxt;
    hold_sym_r   <= hold_sym_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
